// File: design/assert_macros.svh
// Assertion macros for the checker file of the 3x3 blur block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock, off while reset is low
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion sampled on the rising clock, active during reset too
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/bb3_pkg.sv
// Shared types, constants and functions of the 3x3 RGB box blur.
// No dependencies; used by bb3_line_buf and box_blur_3x3_rgb_unit.
package bb3_pkg;

    // Frame geometry and line store sizing
    localparam int unsigned MAX_WIDTH = 1024;
    localparam int unsigned LB_AW     = $clog2(MAX_WIDTH);
    localparam int unsigned COL_W     = LB_AW;
    localparam int unsigned WIDTH_W   = 11;
    localparam int unsigned HEIGHT_W  = 16;
    localparam int unsigned ROW_W     = HEIGHT_W + 1;
    localparam int unsigned CNT_W     = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;

    // Pixel and arithmetic widths
    localparam int unsigned CH_W   = 8;
    localparam int unsigned PIX_W  = 3 * CH_W;
    localparam int unsigned SUM_W  = 12;

    // Register defaults
    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(1024);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(768);

    // Configuration bus
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned APB_DW  = 32;

    // Reciprocals for rounding division by 6 and by 18 (scaled by 2^RECIP_SHIFT)
    localparam int unsigned RECIP_SHIFT = 20;
    localparam logic [17:0] RECIP_6     = 18'd174763;
    localparam logic [17:0] RECIP_18    = 18'd58255;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    // Number of in-frame neighbours
    typedef enum logic [1:0] {
        CNT_4,
        CNT_6,
        CNT_9
    } t_cnt;

    typedef struct packed {
        logic             en;
        logic [LB_AW-1:0] addr;
    } t_lb_rd;

    typedef struct packed {
        logic             en;
        logic [LB_AW-1:0] addr;
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] lower;
    } t_lb_wr;

    // Position of an output pixel relative to the frame border
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
        logic last;
    } t_edge;

    // Mean of n samples, rounded half up: (2*s + n) / (2*n)
    function automatic logic [CH_W-1:0] bb3_mean(input logic [SUM_W-1:0] s, input t_cnt n);
        logic [SUM_W+1:0] x;
        logic [31:0]      prod;
        logic [CH_W-1:0]  res;
        x    = '0;
        prod = '0;
        res  = '0;
        unique case (n)
            CNT_4: begin
                x   = (SUM_W+2)'(s) + (SUM_W+2)'(2);
                res = x[CH_W+1:2];
            end
            CNT_6: begin
                x    = (SUM_W+2)'(s) + (SUM_W+2)'(3);
                prod = 32'(x) * 32'(RECIP_6);
                res  = prod[RECIP_SHIFT +: CH_W];
            end
            CNT_9: begin
                x    = {1'b0, s, 1'b0} + (SUM_W+2)'(9);
                prod = 32'(x) * 32'(RECIP_18);
                res  = prod[RECIP_SHIFT +: CH_W];
            end
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

// File: design/bb3_line_buf.sv
// Two line stores (two rows up, one row up) in synchronous single-port-write RAMs.
// Depends on bb3_pkg; clears both stores after reset and forwards same-entry writes.
module bb3_line_buf (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bb3_pkg::t_lb_rd            i_rd,
    input  bb3_pkg::t_lb_wr            i_wr,
    output logic [bb3_pkg::PIX_W-1:0]  o_upper,
    output logic [bb3_pkg::PIX_W-1:0]  o_lower,
    output logic                       o_busy
);

    localparam int unsigned CLR_W = bb3_pkg::LB_AW + 1;

    logic [bb3_pkg::PIX_W-1:0] r_mem_upper [bb3_pkg::MAX_WIDTH];
    logic [bb3_pkg::PIX_W-1:0] r_mem_lower [bb3_pkg::MAX_WIDTH];

    logic [CLR_W-1:0]          r_clr_cnt;
    logic [bb3_pkg::PIX_W-1:0] r_rd_upper;
    logic [bb3_pkg::PIX_W-1:0] r_rd_lower;
    logic                      r_fwd;
    logic [bb3_pkg::PIX_W-1:0] r_fwd_upper;
    logic [bb3_pkg::PIX_W-1:0] r_fwd_lower;

    logic                      wr_en;
    logic [bb3_pkg::LB_AW-1:0] wr_addr;
    logic [bb3_pkg::PIX_W-1:0] wr_upper;
    logic [bb3_pkg::PIX_W-1:0] wr_lower;

    assign o_busy = (r_clr_cnt < CLR_W'(bb3_pkg::MAX_WIDTH));

    // Clearing pass: one entry of each store per cycle after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (o_busy) begin
            r_clr_cnt <= r_clr_cnt + CLR_W'(1);
        end
    end

    // Select the write: clearing pass first, then the pipeline write-back
    always_comb begin
        if (o_busy) begin
            wr_en    = 1'b1;
            wr_addr  = r_clr_cnt[bb3_pkg::LB_AW-1:0];
            wr_upper = '0;
            wr_lower = '0;
        end else begin
            wr_en    = i_wr.en;
            wr_addr  = i_wr.addr;
            wr_upper = i_wr.upper;
            wr_lower = i_wr.lower;
        end
    end

    // Storage arrays with registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_upper[wr_addr] <= wr_upper;
            r_mem_lower[wr_addr] <= wr_lower;
        end
        if (i_rd.en) begin
            r_rd_upper <= r_mem_upper[i_rd.addr];
            r_rd_lower <= r_mem_lower[i_rd.addr];
        end
    end

    // Catch a write to the entry being read at the same edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd.en) begin
            r_fwd <= i_wr.en && (i_wr.addr == i_rd.addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_fwd_upper <= i_wr.upper;
            r_fwd_lower <= i_wr.lower;
        end
    end

    assign o_upper = r_fwd ? r_fwd_upper : r_rd_upper;
    assign o_lower = r_fwd ? r_fwd_lower : r_rd_lower;

endmodule

// File: design/box_blur_3x3_rgb_unit.sv
// Top level of the 3x3 RGB box blur: stream in, stream out, APB register port.
// Depends on bb3_pkg and bb3_line_buf.
//
// Input stream: one transaction per pixel in raster order, tdata = {blue, green, red},
// tuser[0] = 1 marks a flush tick. Flush ticks before the last pixel of a frame are
// taken and dropped. After the last pixel, frame_width + 1 further transactions
// (flush ticks or pixels, whose data is dropped) drain the remaining outputs.
// Output stream: one blurred pixel per output, tlast on the final pixel of a frame.
// Output k of a frame is caused by input k + frame_width + 1 and moves from that
// input transaction through stages B, C and D into the output register.
// Throughput: one transaction per cycle unless the output stalls; each transaction does
// one read and one write-back of the line stores, whose RAM ports set that rate.
// Registers: frame_width at byte 0 (reset 1024), frame_height at byte 4 (reset 768);
// write them only while the block is idle.
// Reset: a clearing pass zeros all 1024 entries of the line stores; s_axis_tready stays
// low during it while register writes are taken as usual.
// Stall: a result waiting on m_axis_tready holds in the output register; the
// pipeline keeps accepting until every stage behind it is full.
module box_blur_3x3_rgb_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // stream in
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [23:0]                   s_axis_tdata,   // [7:0] in_red, [15:8] in_green,
                                                          // [23:16] in_blue
    input  logic [0:0]                    s_axis_tuser,   // [0] mode
    // stream out
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [23:0]                   m_axis_tdata,   // [7:0] out_red, [15:8] out_green,
                                                          // [23:16] out_blue
    output logic                          m_axis_tlast,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bb3_pkg::PADDR_W-1:0]   paddr,
    input  logic [bb3_pkg::APB_DW-1:0]    pwdata,
    output logic [bb3_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int unsigned CH_W  = bb3_pkg::CH_W;
    localparam int unsigned PIX_W = bb3_pkg::PIX_W;
    localparam int unsigned SUM_W = bb3_pkg::SUM_W;
    localparam int unsigned CNT_W = bb3_pkg::CNT_W;
    localparam int unsigned ROW_W = bb3_pkg::ROW_W;
    localparam int unsigned COL_W = bb3_pkg::COL_W;

    // Configuration registers
    logic [bb3_pkg::WIDTH_W-1:0]  r_frame_width;
    logic [bb3_pkg::HEIGHT_W-1:0] r_frame_height;

    // Frame position of the next input
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;

    // Stage B: waiting on line store read data
    logic                 r_b_v;
    logic                 r_b_out;
    bb3_pkg::t_edge       r_b_edge;
    logic [PIX_W-1:0]     r_b_data;
    logic [COL_W-1:0]     r_b_col;

    // Stage C: window ready for summing
    logic                 r_c_v;
    bb3_pkg::t_edge       r_c_edge;
    logic [PIX_W-1:0]     r_win [9];

    // Stage D: channel sums
    logic                 r_d_v;
    logic [SUM_W-1:0]     r_d_sum_r;
    logic [SUM_W-1:0]     r_d_sum_g;
    logic [SUM_W-1:0]     r_d_sum_b;
    bb3_pkg::t_cnt        r_d_cnt;
    logic                 r_d_last;

    // Output register
    logic                 r_o_v;
    logic [PIX_W-1:0]     r_o_data;
    logic                 r_o_last;

    // Combinational signals
    logic [CNT_W-1:0]     w_eff;
    logic [ROW_W-1:0]     h_eff;
    logic [ROW_W-1:0]     h_p1;
    logic [CNT_W-1:0]     col_a;
    logic [ROW_W-1:0]     row_a;
    logic [CNT_W-1:0]     col_b;
    logic [ROW_W-1:0]     row_b;
    logic                 drain;
    logic                 ignore;
    logic                 has_out;
    bb3_pkg::t_edge       edge_a;
    logic [PIX_W-1:0]     pix_in;

    logic                 acc;
    logic                 go;
    logic                 out_free;
    logic                 d_free;
    logic                 d_move;
    logic                 c_free;
    logic                 c_move;
    logic                 b_free;
    logic                 b_move;

    bb3_pkg::t_lb_rd      lb_rd;
    bb3_pkg::t_lb_wr      lb_wr;
    logic [PIX_W-1:0]     lb_upper;
    logic [PIX_W-1:0]     lb_lower;
    logic                 lb_busy;

    logic [2:0]           row_en;
    logic [2:0]           col_en;
    logic [SUM_W-1:0]     sum_r;
    logic [SUM_W-1:0]     sum_g;
    logic [SUM_W-1:0]     sum_b;
    bb3_pkg::t_cnt        cnt_c;

    logic                 cfg_wr;

    // ---------------------------------------------------------------- registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bb3_pkg::WIDTH_RST;
            r_frame_height <= bb3_pkg::HEIGHT_RST;
        end else if (cfg_wr) begin
            unique case (bb3_pkg::t_reg_idx'(paddr[2]))
                bb3_pkg::REG_FRAME_WIDTH:  r_frame_width  <= pwdata[bb3_pkg::WIDTH_W-1:0];
                bb3_pkg::REG_FRAME_HEIGHT: r_frame_height <= pwdata[bb3_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (bb3_pkg::t_reg_idx'(paddr[2]))
            bb3_pkg::REG_FRAME_WIDTH:  prdata = bb3_pkg::APB_DW'(r_frame_width);
            bb3_pkg::REG_FRAME_HEIGHT: prdata = bb3_pkg::APB_DW'(r_frame_height);
            default:                   prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- handshake
    assign out_free = !r_o_v || m_axis_tready;
    assign d_free   = !r_d_v || out_free;
    assign d_move   = r_d_v && out_free;
    assign c_free   = !r_c_v || d_free;
    assign c_move   = r_c_v && d_free;
    assign b_free   = !r_b_v || c_free;
    assign b_move   = r_b_v && c_free;

    assign s_axis_tready = b_free && !lb_busy;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign go            = acc && !ignore;

    // ---------------------------------------------------------------- frame position
    // Clamp sizes, wrap a stale position, then classify the incoming item
    always_comb begin
        if (r_frame_width < bb3_pkg::WIDTH_W'(2)) begin
            w_eff = CNT_W'(2);
        end else if (CNT_W'(r_frame_width) > CNT_W'(bb3_pkg::MAX_WIDTH)) begin
            w_eff = CNT_W'(bb3_pkg::MAX_WIDTH);
        end else begin
            w_eff = CNT_W'(r_frame_width);
        end
        h_eff = (r_frame_height < bb3_pkg::HEIGHT_W'(2)) ? ROW_W'(2) : ROW_W'(r_frame_height);
        h_p1  = h_eff + ROW_W'(1);

        col_a = CNT_W'(r_col);
        row_a = r_row;
        if (col_a >= w_eff) begin
            col_a = '0;
            row_a = row_a + ROW_W'(1);
        end
        if (row_a > h_p1 || (row_a == h_p1 && col_a != '0)) begin
            row_a = '0;
            col_a = '0;
        end

        drain  = (row_a >= h_eff);
        ignore = !drain && s_axis_tuser[0];
        pix_in = drain ? '0 : {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};

        // Output pixel lags by one row plus one pixel
        has_out       = (row_a >= ROW_W'(2)) || (row_a == ROW_W'(1) && col_a != '0);
        edge_a.last   = (row_a == h_p1) && (col_a == '0);
        edge_a.top    = (col_a != '0) ? (row_a == ROW_W'(1)) : (row_a == ROW_W'(2));
        edge_a.bottom = (col_a != '0) ? (row_a == h_eff) : (row_a == h_p1);
        edge_a.left   = (col_a == CNT_W'(1));
        edge_a.right  = (col_a == '0);

        col_b = col_a + CNT_W'(1);
        row_b = row_a;
        if (col_b >= w_eff) begin
            col_b = '0;
            row_b = row_a + ROW_W'(1);
        end
        if (edge_a.last) begin
            col_b = '0;
            row_b = '0;
        end

        if (ignore) begin
            n_col = col_a[COL_W-1:0];
            n_row = row_a;
        end else begin
            n_col = col_b[COL_W-1:0];
            n_row = row_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------------------------------------------------------- line stores
    assign lb_rd.en    = go;
    assign lb_rd.addr  = col_a[COL_W-1:0];
    assign lb_wr.en    = b_move;
    assign lb_wr.addr  = r_b_col;
    assign lb_wr.upper = lb_lower;
    assign lb_wr.lower = r_b_data;

    bb3_line_buf u_line_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (lb_rd),
        .i_wr    (lb_wr),
        .o_upper (lb_upper),
        .o_lower (lb_lower),
        .o_busy  (lb_busy)
    );

    // ---------------------------------------------------------------- pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (go) begin
                r_b_v <= 1'b1;
            end else if (b_move) begin
                r_b_v <= 1'b0;
            end

            if (b_move) begin
                r_c_v <= r_b_out;
            end else if (c_move) begin
                r_c_v <= 1'b0;
            end

            if (c_move) begin
                r_d_v <= 1'b1;
            end else if (d_move) begin
                r_d_v <= 1'b0;
            end

            if (d_move) begin
                r_o_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    // Stage B payload
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_b_out  <= has_out;
            r_b_edge <= edge_a;
            r_b_data <= pix_in;
            r_b_col  <= col_a[COL_W-1:0];
        end
    end

    // Shift the window one column and load the newest column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (b_move) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]   <= r_win[r*3+1];
                r_win[r*3+1] <= r_win[r*3+2];
            end
            r_win[2] <= lb_upper;
            r_win[5] <= lb_lower;
            r_win[8] <= r_b_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_move) begin
            r_c_edge <= r_b_edge;
        end
    end

    // Sum the in-frame neighbours per channel
    always_comb begin
        row_en = {!r_c_edge.bottom, 1'b1, !r_c_edge.top};
        col_en = {!r_c_edge.right, 1'b1, !r_c_edge.left};
        sum_r  = '0;
        sum_g  = '0;
        sum_b  = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (row_en[r] && col_en[c]) begin
                    sum_r = sum_r + SUM_W'(r_win[r*3+c][2*CH_W +: CH_W]);
                    sum_g = sum_g + SUM_W'(r_win[r*3+c][CH_W +: CH_W]);
                    sum_b = sum_b + SUM_W'(r_win[r*3+c][0 +: CH_W]);
                end
            end
        end
        priority if ((r_c_edge.top || r_c_edge.bottom) && (r_c_edge.left || r_c_edge.right)) begin
            cnt_c = bb3_pkg::CNT_4;
        end else if (r_c_edge.top || r_c_edge.bottom || r_c_edge.left || r_c_edge.right) begin
            cnt_c = bb3_pkg::CNT_6;
        end else begin
            cnt_c = bb3_pkg::CNT_9;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_move) begin
            r_d_sum_r <= sum_r;
            r_d_sum_g <= sum_g;
            r_d_sum_b <= sum_b;
            r_d_cnt   <= cnt_c;
            r_d_last  <= r_c_edge.last;
        end
    end

    // Divide by the neighbour count into the output register
    always_ff @(posedge i_clk) begin
        if (d_move) begin
            r_o_data <= {bb3_pkg::bb3_mean(r_d_sum_b, r_d_cnt),
                         bb3_pkg::bb3_mean(r_d_sum_g, r_d_cnt),
                         bb3_pkg::bb3_mean(r_d_sum_r, r_d_cnt)};
            r_o_last <= r_d_last;
        end
    end

    assign m_axis_tvalid = r_o_v;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tlast  = r_o_last;

endmodule

// File: design/bb3_checker.sv
// Port-level checks of box_blur_3x3_rgb_unit, attached with a bind below.
// Depends on assert_macros.svh and bb3_pkg.
`include "assert_macros.svh"

module bb3_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [23:0]                   m_axis_tdata,
    input logic                          m_axis_tlast,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [bb3_pkg::PADDR_W-1:0]   paddr,
    input logic [bb3_pkg::APB_DW-1:0]    pwdata,
    input logic [bb3_pkg::APB_DW-1:0]    prdata,
    input logic                          pready
);

    // Hold a stalled result
    `ASSERT_RST(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output transaction changed")

    // Drop valid only after the result was taken
    `ASSERT_RST(a_out_drop, i_clk, i_rst_n, $fell(m_axis_tvalid) && $past(i_rst_n) |-> $past(m_axis_tready), "output transaction lost")

    // Line store clearing keeps the input closed right after reset
    `ASSERT_CLK(a_rst_clear, i_clk, !i_rst_n |=> !s_axis_tready && !m_axis_tvalid, "input open or output valid right after reset")

    // Width register reads back what was written
    `ASSERT_RST(a_width_rb, i_clk, i_rst_n, i_rst_n && psel && penable && pwrite && pready && !paddr[2] |=> paddr[2] || prdata[10:0] == $past(pwdata[10:0]), "frame_width readback mismatch")

endmodule

bind box_blur_3x3_rgb_unit bb3_checker u_bb3_checker (.*);

// File: tb/box_blur_3x3_rgb_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for box_blur_3x3_rgb_unit: a directed frame table, then random frames
// under several idling patterns, every output compared with a table value or an in-bench blur predictor.
// Depends on bb3_pkg and the design sources of box_blur_3x3_rgb_unit.
module box_blur_3x3_rgb_unit_tb;

    localparam int unsigned CH_W      = bb3_pkg::CH_W;
    localparam int unsigned PIX_W     = bb3_pkg::PIX_W;
    localparam int unsigned WIDTH_W   = bb3_pkg::WIDTH_W;
    localparam int unsigned HEIGHT_W  = bb3_pkg::HEIGHT_W;
    localparam int unsigned MAX_WIDTH = bb3_pkg::MAX_WIDTH;
    localparam int unsigned PADDR_W   = bb3_pkg::PADDR_W;
    localparam int unsigned APB_DW    = bb3_pkg::APB_DW;

    localparam int          CLK_HALF    = 4;
    localparam int          RST_CYCLES  = 12;
    localparam int          DRAIN_WAIT  = 10;
    localparam int          STUCK_LIMIT = 20000;
    localparam int unsigned RAND_ITEMS  = 1400;
    localparam int          HOLD_CYCLES = 300;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            fend;
    } t_blur_pix;

    typedef enum logic [1:0] {ROW_SET_W, ROW_SET_H, ROW_ITEM} t_row_kind;
    typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_GIVEN} t_exp_kind;

    typedef struct packed {
        t_row_kind       kind;
        logic [15:0]     value;   // register value on ROW_SET_*
        logic            mode;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        t_exp_kind       chk;
        t_blur_pix       given;
    } t_dir_row;

    localparam t_blur_pix NO_PIX    = '0;
    localparam t_blur_pix WHITE     = '{8'hff, 8'hff, 8'hff, 1'b0};
    localparam t_blur_pix WHITE_END = '{8'hff, 8'hff, 8'hff, 1'b1};
    localparam t_blur_pix BLACK     = '{8'h00, 8'h00, 8'h00, 1'b0};
    localparam t_blur_pix BLACK_END = '{8'h00, 8'h00, 8'h00, 1'b1};

    // Directed frames: 2x2 white, 2x2 black with a stray flush, 3x2 mixed extremes
    localparam t_dir_row DIR_TAB [29] = '{
        '{ROW_SET_W, 16'd2, MODE_PIXEL, 8'h00, 8'h00, 8'h00, EXP_NONE,  NO_PIX},
        '{ROW_SET_H, 16'd2, MODE_PIXEL, 8'h00, 8'h00, 8'h00, EXP_NONE,  NO_PIX},
        '{ROW_ITEM,  16'd0, MODE_FLUSH, 8'h00, 8'h00, 8'h00, EXP_NONE,  NO_PIX},
        '{ROW_ITEM,  16'd0, MODE_PIXEL, 8'hff, 8'hff, 8'hff, EXP_NONE,  NO_PIX},
        '{ROW_ITEM,  16'd0, MODE_PIXEL, 8'hff, 8'hff, 8'hff, EXP_NONE,  NO_PIX},
        '{ROW_ITEM,  16'd0, MODE_PIXEL, 8'hff, 8'hff, 8'hff, EXP_NONE,  NO_PIX},
        '{ROW_ITEM,  16'd0, MODE_PIXEL, 8'hff, 8'hff, 8'hff, EXP_GIVEN, WHITE},
        '{ROW_ITEM,  16'd0, MODE_FLUSH, 8'h00, 8'h00, 8'h00, EXP_GIVEN, WHITE},
        '{ROW_ITEM,  16'd0, MODE_PIXEL, 8'h12, 8'h34, 8'h56, EXP_GIVEN, WHITE},
        '{ROW_ITEM,  16'd0, MODE_FLUSH, 8'h00, 8'h00, 8'h00, EXP_GIVEN, WHITE_END},
        '{ROW_ITEM,  16'd0, MODE_PIXEL, 8'h00, 8'h00, 8'h00, EXP_NONE,  NO_PIX},
        '{ROW_ITEM,  16'd0, MODE_PIXEL, 8'h00, 8'h00, 8'h00, EXP_NONE,  NO_PIX},
        '{ROW_ITEM,  16'd0, MODE_FLUSH, 8'hff, 8'hff, 8'hff, EXP_NONE,  NO_PIX},
        '{ROW_ITEM,  16'd0, MODE_PIXEL, 8'h00, 8'h00, 8'h00, EXP_NONE,  NO_PIX},
        '{ROW_ITEM,  16'd0, MODE_PIXEL, 8'h00, 8'h00, 8'h00, EXP_GIVEN, BLACK},
        '{ROW_ITEM,  16'd0, MODE_FLUSH, 8'h00, 8'h00, 8'h00, EXP_GIVEN, BLACK},
        '{ROW_ITEM,  16'd0, MODE_PIXEL, 8'hff, 8'hff, 8'hff, EXP_GIVEN, BLACK},
        '{ROW_ITEM,  16'd0, MODE_FLUSH, 8'h00, 8'h00, 8'h00, EXP_GIVEN, BLACK_END},
        '{ROW_SET_W, 16'd3, MODE_PIXEL, 8'h00, 8'h00, 8'h00, EXP_NONE,  NO_PIX},
        '{ROW_ITEM,  16'd0, MODE_PIXEL, 8'h00, 8'hff, 8'h01, EXP_MODEL, NO_PIX},
        '{ROW_ITEM,  16'd0, MODE_PIXEL, 8'hff, 8'h00, 8'h80, EXP_MODEL, NO_PIX},
        '{ROW_ITEM,  16'd0, MODE_PIXEL, 8'h7f, 8'h80, 8'hfe, EXP_MODEL, NO_PIX},
        '{ROW_ITEM,  16'd0, MODE_PIXEL, 8'h01, 8'hfe, 8'h00, EXP_MODEL, NO_PIX},
        '{ROW_ITEM,  16'd0, MODE_PIXEL, 8'h55, 8'haa, 8'h33, EXP_MODEL, NO_PIX},
        '{ROW_ITEM,  16'd0, MODE_PIXEL, 8'hfe, 8'h01, 8'hff, EXP_MODEL, NO_PIX},
        '{ROW_ITEM,  16'd0, MODE_FLUSH, 8'h00, 8'h00, 8'h00, EXP_MODEL, NO_PIX},
        '{ROW_ITEM,  16'd0, MODE_FLUSH, 8'h00, 8'h00, 8'h00, EXP_MODEL, NO_PIX},
        '{ROW_ITEM,  16'd0, MODE_PIXEL, 8'h12, 8'h34, 8'h56, EXP_MODEL, NO_PIX},
        '{ROW_ITEM,  16'd0, MODE_FLUSH, 8'h00, 8'h00, 8'h00, EXP_MODEL, NO_PIX}
    };

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata  = '0;  // [7:0] in_red, [15:8] in_green, [23:16] in_blue
    logic [0:0]           s_axis_tuser  = '0;  // [0] mode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [23:0]          m_axis_tdata;        // [7:0] out_red, [15:8] out_green, [23:16] out_blue
    logic                 m_axis_tlast;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [PADDR_W-1:0]   paddr         = '0;
    logic [APB_DW-1:0]    pwdata        = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // Predictor copy of the block state
    logic [WIDTH_W-1:0]   cfg_width;
    logic [HEIGHT_W-1:0]  cfg_height;
    logic [PIX_W-1:0]     upper_line [MAX_WIDTH];
    logic [PIX_W-1:0]     lower_line [MAX_WIDTH];
    logic [PIX_W-1:0]     win [9];
    int unsigned          col_pos;
    int unsigned          row_pos;
    t_blur_pix            pending_pix [$];

    int unsigned          idle_pct    = 0;
    int unsigned          stall_pct   = 0;
    int unsigned          mismatches  = 0;
    bit                   hold_req    = 1'b0;
    bit                   hold_taken  = 1'b0;
    int                   hold_left   = 0;
    int                   stuck_cnt   = 0;

    box_blur_3x3_rgb_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Clamp the frame sizes the way the block does
    function automatic int unsigned width_eff();
        if (cfg_width < 2) return 2;
        if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
        return cfg_width;
    endfunction

    function automatic int unsigned height_eff();
        return (cfg_height < 2) ? 2 : cfg_height;
    endfunction

    function automatic void blur_reset();
        cfg_width  = bb3_pkg::WIDTH_RST;
        cfg_height = bb3_pkg::HEIGHT_RST;
        foreach (upper_line[i]) begin
            upper_line[i] = '0;
            lower_line[i] = '0;
        end
        foreach (win[i]) win[i] = '0;
        col_pos = 0;
        row_pos = 0;
    endfunction

    // Advance the blur by one input; used is low for an ignored flush
    function automatic void blur_step(input logic mode, input logic [CH_W-1:0] r, g, b,
                                      output bit used, output bit got, output t_blur_pix res);
        int unsigned      w, h, col, n, orow, ocol, sr, sg, sb, i, j;
        logic [PIX_W-1:0] data, up, lo, v;
        logic [63:0]      p, q;
        bit               drain;
        w    = width_eff();
        h    = height_eff();
        used = 1'b0;
        got  = 1'b0;
        res  = '0;
        // Fold a stale position into the current frame size
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos > h + 1 || (row_pos == h + 1 && col_pos > 0)) begin
            row_pos = 0;
            col_pos = 0;
        end
        drain = row_pos >= h;
        if (!drain && mode == MODE_FLUSH) return;
        used = 1'b1;
        data = drain ? '0 : {r, g, b};

        // Shift the line stores and the window
        col = col_pos % MAX_WIDTH;
        up  = upper_line[col];
        lo  = lower_line[col];
        upper_line[col] = lo;
        lower_line[col] = data;
        for (i = 0; i < 3; i++) begin
            win[3*i]   = win[3*i+1];
            win[3*i+1] = win[3*i+2];
        end
        win[2] = up;
        win[5] = lo;
        win[8] = data;

        p = 64'(row_pos) * w + col_pos;
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (p < 64'(w) + 1) return;
        q = p - w - 1;
        if (q >= 64'(w) * h) return;

        // Average the in-frame neighbours, rounding half up
        orow = 32'(q / w);
        ocol = 32'(q % w);
        sr = 0;
        sg = 0;
        sb = 0;
        n  = 0;
        for (i = 0; i < 3; i++) begin
            if ((i == 0 && orow == 0) || (i == 2 && orow == h - 1)) continue;
            for (j = 0; j < 3; j++) begin
                if ((j == 0 && ocol == 0) || (j == 2 && ocol == w - 1)) continue;
                v  = win[3*i+j];
                sr += v[23:16];
                sg += v[15:8];
                sb += v[7:0];
                n++;
            end
        end
        res.red   = CH_W'((2 * sr + n) / (2 * n));
        res.green = CH_W'((2 * sg + n) / (2 * n));
        res.blue  = CH_W'((2 * sb + n) / (2 * n));
        res.fend  = (q == 64'(w) * h - 1);
        got = 1'b1;
        if (res.fend) begin
            row_pos = 0;
            col_pos = 0;
        end
    endfunction

    // Register write: setup cycle, then access cycle
    task automatic reg_write(input bb3_pkg::t_reg_idx idx, input logic [APB_DW-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == bb3_pkg::REG_FRAME_WIDTH) cfg_width = val[WIDTH_W-1:0];
        else cfg_height = val[HEIGHT_W-1:0];
    endtask

    // Offer one transaction, hold it until taken, then record what it should produce
    task automatic send_item(input logic mode, input logic [CH_W-1:0] r, g, b,
                             input t_exp_kind chk, input t_blur_pix given, output bit used);
        t_blur_pix res;
        bit        got;
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, g, r};
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        blur_step(mode, r, g, b, used, got, res);
        if (chk == EXP_GIVEN) pending_pix.push_back(given);
        else if (chk == EXP_MODEL && got) pending_pix.push_back(res);
    endtask

    task automatic send_random(input int unsigned n, inout int unsigned counted);
        logic [CH_W-1:0] ch [3];
        logic            mode;
        bit              used;
        repeat (n) begin
            mode = ($urandom_range(99) < 5) ? MODE_FLUSH : MODE_PIXEL;
            foreach (ch[k]) begin
                if ($urandom_range(99) < 15) ch[k] = $urandom_range(1) ? 8'hff : 8'h00;
                else ch[k] = CH_W'($urandom);
            end
            send_item(mode, ch[0], ch[1], ch[2], EXP_MODEL, NO_PIX, used);
            if (used) counted++;
        end
    endtask

    // Drop valid, let every pending output arrive, then let the pipeline empty
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_pix.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Check each output transaction, then pick the next ready
    always @(posedge i_clk) begin
        t_blur_pix want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pix.size() == 0) begin
                $error("output transaction with nothing pending: tdata %h tlast %b",
                       m_axis_tdata, m_axis_tlast);
                mismatches++;
            end else begin
                want = pending_pix.pop_front();
                if (m_axis_tdata[7:0] !== want.red) begin
                    $error("out_red: expected %0d, got %0d", want.red, m_axis_tdata[7:0]);
                    mismatches++;
                end
                if (m_axis_tdata[15:8] !== want.green) begin
                    $error("out_green: expected %0d, got %0d", want.green, m_axis_tdata[15:8]);
                    mismatches++;
                end
                if (m_axis_tdata[23:16] !== want.blue) begin
                    $error("out_blue: expected %0d, got %0d", want.blue, m_axis_tdata[23:16]);
                    mismatches++;
                end
                if (m_axis_tlast !== want.fend) begin
                    $error("frame_end: expected %0d, got %0d", want.fend, m_axis_tlast);
                    mismatches++;
                end
            end
        end
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // End the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stuck_cnt <= 0;
        end else if (stuck_cnt >= STUCK_LIMIT) begin
            $display("box_blur_3x3_rgb_unit: mismatch");
            $finish;
        end else begin
            stuck_cnt <= stuck_cnt + 1;
        end
    end

    initial begin
        t_dir_row    row;
        bit          used;
        int unsigned ph, rand_done, w, h, full, n;
        int unsigned w_val, h_val;
        blur_reset();
        ph        = 0;
        rand_done = 0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table with no idling
        foreach (DIR_TAB[k]) begin
            row = DIR_TAB[k];
            unique case (row.kind)
                ROW_SET_W: begin
                    wait_idle();
                    reg_write(bb3_pkg::REG_FRAME_WIDTH, APB_DW'(row.value));
                end
                ROW_SET_H: begin
                    wait_idle();
                    reg_write(bb3_pkg::REG_FRAME_HEIGHT, APB_DW'(row.value));
                end
                default: begin
                    send_item(row.mode, row.red, row.green, row.blue, row.chk, row.given, used);
                end
            endcase
        end

        // Random frames, phase by phase
        while (rand_done < RAND_ITEMS) begin
            wait_idle();
            unique case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 86; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 86; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            if (ph == 1) begin
                // Long receiver hold while the sender keeps offering
                reg_write(bb3_pkg::REG_FRAME_WIDTH, 4);
                reg_write(bb3_pkg::REG_FRAME_HEIGHT, 40);
                hold_req = 1'b1;
                send_random(4 * 40 + 5, rand_done);
            end else if (ph == 2) begin
                // Widest frame: clamped width first, then the exact maximum mid-frame
                reg_write(bb3_pkg::REG_FRAME_WIDTH, 2047);
                reg_write(bb3_pkg::REG_FRAME_HEIGHT, 2);
                send_random(520, rand_done);
                wait_idle();
                reg_write(bb3_pkg::REG_FRAME_WIDTH, MAX_WIDTH);
                send_random(520, rand_done);
            end else begin
                n = $urandom_range(99);
                w_val = (n < 8) ? $urandom_range(1) : $urandom_range(9, 2);
                n = $urandom_range(99);
                if (n < 8) h_val = $urandom_range(1);
                else if (n < 14 || ph == 3) h_val = 65535;
                else h_val = $urandom_range(7, 2);
                if (ph == 0 || $urandom_range(9) < 7) reg_write(bb3_pkg::REG_FRAME_WIDTH, w_val);
                if (ph == 0 || $urandom_range(9) < 7) reg_write(bb3_pkg::REG_FRAME_HEIGHT, h_val);
                w    = width_eff();
                h    = height_eff();
                full = w * h + w + 1;
                if (full > 300) n = $urandom_range(200, 30);
                else if ($urandom_range(3) == 0) n = $urandom_range(full, 1);
                else n = full;
                send_random(n, rand_done);
            end
            ph++;
        end

        wait_idle();
        if (mismatches == 0 && pending_pix.size() == 0) begin
            $display("box_blur_3x3_rgb_unit: match");
        end else begin
            $display("box_blur_3x3_rgb_unit: mismatch");
        end
        $finish;
    end

endmodule

// File: box_blur_3x3_rgb_unit.f
+incdir+design
design/bb3_pkg.sv
design/bb3_line_buf.sv
design/box_blur_3x3_rgb_unit.sv
design/bb3_checker.sv
tb/box_blur_3x3_rgb_unit_tb.sv
